// ----- rtl/core/support_point_search_assert.svh -----
// Assertion macros shared by the support point search RTL.
`ifndef SUPPORT_POINT_SEARCH_ASSERT_SVH
`define SUPPORT_POINT_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("support_point_search assertion failed");
`define SPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("support_point_search assertion failed");
`else
`define SPS_ASSERT(label, clk, rstn, prop)
`define SPS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/core/sps_pkg.sv -----
`timescale 1ns / 1ps

package sps_pkg;

    localparam int COORD_W = 24;
    localparam int DIR_W   = 16;
    localparam int DOT_W   = 40;
    localparam int SUM_W   = DOT_W + 2;
    localparam int IDX_W   = 16;
    localparam int LANE_W  = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 2'd2;

    localparam logic signed [DIR_W-1:0] DIR_X_RESET = 16'sd16384;
    localparam logic signed [DIR_W-1:0] DIR_Y_RESET = 16'sd0;
    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 16'sd0;

    localparam logic signed [DOT_W-1:0] DOT_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [DOT_W-1:0] DOT_MIN = 40'sh80_0000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef struct packed {
        logic              last;
        logic [IDX_W-1:0]  index;
        logic [LANE_W-1:0] lane;
        coord_t            x;
        coord_t            y;
        coord_t            z;
        dot_t              dot;
    } item_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// ----- rtl/core/sps_front.sv -----
`timescale 1ns / 1ps
`include "support_point_search_assert.svh"

module sps_front #(
    parameter int MAX_VERTICES = 65536,
    parameter int LANE_GROUP   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,
    input  logic                          s_tlast,
    input  logic                          cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sps_pkg::DIR_W-1:0]     cfg_wdata,
    input  sps_pkg::q_status_t            q_status,
    output logic                          push,
    output sps_pkg::item_t                push_item
);
    import sps_pkg::*;

    localparam int CNT_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int LG_W   = (LANE_GROUP > 1) ? $clog2(LANE_GROUP) : 1;
    localparam int FLY_W  = QCNT_W + 1;

    typedef logic [FLY_W-1:0] fly_t;

    dir_t dir_x_reg, dir_y_reg, dir_z_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LG_W-1:0]  lane_reg, lane_next;

    // stage 1: products
    logic             v1_reg;
    dot_t             px_reg, py_reg, pz_reg;
    coord_t           x1_reg, y1_reg, z1_reg;
    logic             last1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [LANE_W-1:0] lane1_reg;

    // stage 2: sum and saturate
    logic  v2_reg;
    item_t item2_reg, item2_next;

    coord_t in_x, in_y, in_z;
    logic   accept;
    logic signed [SUM_W-1:0] sum;

    assign in_x = s_tdata[23:0];
    assign in_y = s_tdata[47:24];
    assign in_z = s_tdata[71:48];

    assign s_tready = (fly_t'(q_status.count) + fly_t'(v1_reg) + fly_t'(v2_reg))
                      < fly_t'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_x_reg <= DIR_X_RESET;
            dir_y_reg <= DIR_Y_RESET;
            dir_z_reg <= DIR_Z_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIR_X: dir_x_reg <= cfg_wdata;
                REG_DIR_Y: dir_y_reg <= cfg_wdata;
                REG_DIR_Z: dir_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        lane_next = lane_reg;
        if (accept) begin
            if (s_tlast || cnt_reg == CNT_W'(MAX_VERTICES - 1)) begin
                cnt_next  = '0;
                lane_next = '0;
            end else begin
                cnt_next  = cnt_reg + 1'b1;
                lane_next = (lane_reg == LG_W'(LANE_GROUP - 1)) ? '0 : lane_reg + 1'b1;
            end
        end
    end

    always_comb begin
        sum = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg);
        item2_next.last  = last1_reg;
        item2_next.index = idx1_reg;
        item2_next.lane  = lane1_reg;
        item2_next.x     = x1_reg;
        item2_next.y     = y1_reg;
        item2_next.z     = z1_reg;
        if (sum[SUM_W-1:DOT_W-1] == '0 || sum[SUM_W-1:DOT_W-1] == '1) begin
            item2_next.dot = sum[DOT_W-1:0];
        end else if (sum[SUM_W-1]) begin
            item2_next.dot = DOT_MIN;
        end else begin
            item2_next.dot = DOT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            lane_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            lane_reg <= lane_next;
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= DOT_W'(in_x * dir_x_reg);
            py_reg    <= DOT_W'(in_y * dir_y_reg);
            pz_reg    <= DOT_W'(in_z * dir_z_reg);
            x1_reg    <= in_x;
            y1_reg    <= in_y;
            z1_reg    <= in_z;
            last1_reg <= s_tlast;
            idx1_reg  <= IDX_W'(cnt_reg);
            lane1_reg <= LANE_W'(lane_reg);
        end
        if (v1_reg) begin
            item2_reg <= item2_next;
        end
    end

    assign push      = v2_reg;
    assign push_item = item2_reg;

    `SPS_ASSERT(a_last_clears_count, aclk, aresetn,
        (accept && s_tlast) |=> (cnt_reg == '0 && lane_reg == '0))
    `SPS_ASSERT(a_stage_advance, aclk, aresetn, v1_reg |=> v2_reg)
    `SPS_ASSERT(a_credit_bound, aclk, aresetn,
        (fly_t'(q_status.count) + fly_t'(v1_reg) + fly_t'(v2_reg)) <= fly_t'(QUEUE_DEPTH))

endmodule

// ----- rtl/core/sps_queue.sv -----
`timescale 1ns / 1ps
`include "support_point_search_assert.svh"

module sps_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sps_pkg::item_t     push_item,
    input  logic               pop,
    output sps_pkg::item_t     head,
    output sps_pkg::q_status_t status
);
    import sps_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    `SPS_ASSERT(a_no_overflow, aclk, aresetn,
        !(push && !pop && count_reg == QCNT_W'(QUEUE_DEPTH)))
    `SPS_ASSERT(a_no_underflow, aclk, aresetn, !(pop && count_reg == '0))
    `SPS_ASSERT(a_ptr_gap, aclk, aresetn,
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)

endmodule

// ----- rtl/core/sps_back.sv -----
`timescale 1ns / 1ps
`include "support_point_search_assert.svh"

module sps_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  sps_pkg::item_t     head,
    input  sps_pkg::q_status_t q_status,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata
);
    import sps_pkg::*;

    logic              have_best_reg, have_best_next;
    dot_t              best_dot_reg, best_dot_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [LANE_W-1:0] best_lane_reg, best_lane_next;
    coord_t            best_x_reg, best_x_next;
    coord_t            best_y_reg, best_y_next;
    coord_t            best_z_reg, best_z_next;

    logic              out_valid_reg, out_valid_next;
    dot_t              out_dot_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    coord_t            out_x_reg, out_y_reg, out_z_reg;

    logic take, emit;

    assign pop  = !q_status.empty && (!head.last || !out_valid_reg || m_tready);
    assign emit = pop && head.last;

    // lane tie rule: equal dot goes to the lower lane
    assign take = !have_best_reg || (head.dot > best_dot_reg) ||
                  (head.dot == best_dot_reg && head.lane < best_lane_reg);

    always_comb begin
        have_best_next = have_best_reg;
        best_dot_next  = best_dot_reg;
        best_idx_next  = best_idx_reg;
        best_lane_next = best_lane_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        best_z_next    = best_z_reg;
        if (pop && take) begin
            best_dot_next  = head.dot;
            best_idx_next  = head.index;
            best_lane_next = head.lane;
            best_x_next    = head.x;
            best_y_next    = head.y;
            best_z_next    = head.z;
        end
        if (pop) begin
            have_best_next = !head.last;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_dot_reg  <= best_dot_next;
        best_idx_reg  <= best_idx_next;
        best_lane_reg <= best_lane_next;
        best_x_reg    <= best_x_next;
        best_y_reg    <= best_y_next;
        best_z_reg    <= best_z_next;
        if (emit) begin
            out_dot_reg <= best_dot_next;
            out_idx_reg <= best_idx_next;
            out_x_reg   <= best_x_next;
            out_y_reg   <= best_y_next;
            out_z_reg   <= best_z_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dot_reg, out_z_reg, out_y_reg, out_x_reg, out_idx_reg};

    `SPS_ASSERT(a_no_emit_over_held, aclk, aresetn,
        !(emit && out_valid_reg && !m_tready))
    `SPS_ASSERT(a_emit_clears, aclk, aresetn, emit |=> (!have_best_reg && m_tvalid))
    `SPS_ASSERT(a_vertex_sets_best, aclk, aresetn, (pop && !head.last) |=> have_best_reg)

endmodule

// ----- rtl/core/support_point_search.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake                Payload
// s_       in   s_tvalid / s_tready      s_tdata: coord_x, coord_y, coord_z; s_tlast: last_vertex
// m_       out  m_tvalid / m_tready      m_tdata: vertex_index, far_x, far_y, far_z, best_dot
// cfg_     in   cfg_wr_en                cfg_index, cfg_wdata (dir_x, dir_y, dir_z)
//
// One vertex per cycle sustained while s_tready is high. A result reaches m_ after its last
// vertex passes the multiply stage, add/saturate stage, four-entry queue, compare and
// output register. Reset (aresetn low, synchronous) empties the pipeline and the
// queue, drops any held result and sets the direction to +X. s_tready falls only
// when the two front stages and the queue together hold four vertices, which
// happens when m_tready stays low while a further last vertex waits in the queue.

module support_point_search #(
    parameter int MAX_VERTICES = 65536,
    parameter int LANE_GROUP   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,   // coord_x, coord_y, coord_z
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,   // vertex_index, far_x, far_y, far_z, best_dot
    input  logic                          cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sps_pkg::DIR_W-1:0]     cfg_wdata
);
    import sps_pkg::*;

    logic      push, pop;
    item_t     push_item, head;
    q_status_t q_status;

    sps_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .LANE_GROUP   (LANE_GROUP)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    sps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
